/* hdl/job_slot_table_with_tickets_top_macros.svh */
// Assertion macros for the job slot table.
// Used by job_slot_table_with_tickets_top; needs clk_i and rst_ni in scope.
`ifndef JOB_SLOT_TABLE_WITH_TICKETS_TOP_MACROS_SVH
`define JOB_SLOT_TABLE_WITH_TICKETS_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset
`define JST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Property whose consequent must hold in the cycle after its antecedent
`define JST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JST_ASSERT(lbl, prop, msg)
`define JST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/jst_pkg.sv */
// Shared types and constants for the job slot table.
// No dependencies; imported by job_slot_table_with_tickets_top.
`timescale 1ns / 1ps

package jst_pkg;

  // Table geometry
  localparam int SLOTS  = 16;
  localparam int SLOT_W = 4;
  localparam int CNT_W  = 5;
  localparam int SALT_W = 16;
  localparam int WORD_W = 32;

  // Stream payload widths (padded to whole bytes)
  localparam int IN_W  = 104;
  localparam int OUT_W = 112;

  // Command codes
  typedef enum logic [2:0] {
    CMD_POST     = 3'd0,
    CMD_TAKE     = 3'd1,
    CMD_COMPLETE = 3'd2,
    CMD_IS_DONE  = 3'd3,
    CMD_IS_VALID = 3'd4
  } cmd_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_RESULT
  } state_e;

endpackage

/* hdl/job_slot_table_with_tickets_top.sv */
// Job slot table with salted tickets: post, take, complete and ticket queries.
// Post and take scan up to 16 slots through the shared slot compare; if refused up front
// they go to the result like unknown codes; complete, is-done and is-valid check one slot.
// Throughput: one request in flight; the next request is taken once the result sits in
// the output register. Reset (rst_ni low, async): all slots free, salts zero, counts zero.
// Depends on jst_pkg and job_slot_table_with_tickets_top_macros.svh.
`timescale 1ns / 1ps
`include "job_slot_table_with_tickets_top_macros.svh"

module job_slot_table_with_tickets_top
  import jst_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // Request: command[2:0], job_handle[34:3], job_argument[66:35],
  // slot_index[70:67], ticket_in[102:71], zero[103]
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,
  // Result: ok[0], ticket_out[32:1], taken_slot[36:33], taken_handle[68:37],
  // taken_argument[100:69], clear_ticket[101], incomplete_count[106:102], zero[111:107]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata
);

  // Request field unpacking
  logic [2:0]        in_cmd;
  logic [WORD_W-1:0] in_handle;
  logic [WORD_W-1:0] in_arg;
  logic [SLOT_W-1:0] in_sidx;
  logic [WORD_W-1:0] in_ticket;
  logic [15:0]       in_raw;

  assign in_cmd    = s_axis_tdata[2:0];
  assign in_handle = s_axis_tdata[34:3];
  assign in_arg    = s_axis_tdata[66:35];
  assign in_sidx   = s_axis_tdata[70:67];
  assign in_ticket = s_axis_tdata[102:71];
  assign in_raw    = in_ticket[15:0];

  // Sequencer and latched request
  state_e            state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  logic [WORD_W-1:0] handle_q, arg_q, ticket_q;
  logic [SLOT_W-1:0] ptr_q, ptr_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic              tv_q, tv_d;

  // Slot table state
  logic [SALT_W-1:0] slot_salt_q [SLOTS];
  logic [SLOTS-1:0]  slot_done_q;
  logic [SLOTS-1:0]  slot_taken_q;
  logic [WORD_W-1:0] slot_handle_q [SLOTS];
  logic [WORD_W-1:0] slot_arg_q [SLOTS];
  logic [SLOT_W-1:0] scan_start_q;
  logic [CNT_W-1:0]  pending_q;
  logic [CNT_W-1:0]  ready_q;

  // Pending result
  logic              res_ok_q, res_ok_d;
  logic [WORD_W-1:0] res_ticket_q, res_ticket_d;
  logic [SLOT_W-1:0] res_tslot_q, res_tslot_d;
  logic              res_clr_q, res_clr_d;
  logic [WORD_W-1:0] res_thandle_q, res_targ_q;

  // Output register
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q;

  logic              s_accept;
  logic              post_hit, take_hit, cmpl_hit, out_load;
  logic              cur_done, cur_taken, salt_match, last_step;
  logic [SLOT_W-1:0] ptr_inc;
  logic [SALT_W-1:0] salt_inc;
  logic [15:0]       slot_field;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Shared slot compare at the scan pointer
  assign cur_done   = slot_done_q[ptr_q];
  assign cur_taken  = slot_taken_q[ptr_q];
  assign salt_match = (slot_salt_q[ptr_q] == ticket_q[31:16]);
  assign last_step  = (cnt_q == SLOT_W'(SLOTS - 1));
  assign ptr_inc    = (ptr_q == SLOT_W'(SLOTS - 1)) ? '0 : ptr_q + 1'b1;
  assign salt_inc   = slot_salt_q[ptr_q] + 1'b1;
  assign slot_field = {{(16 - SLOT_W){1'b0}}, ptr_q} + 16'd1;

  // Next state, scan stepping and result
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    ptr_d        = ptr_q;
    cnt_d        = cnt_q;
    tv_d         = tv_q;
    res_ok_d     = res_ok_q;
    res_ticket_d = res_ticket_q;
    res_tslot_d  = res_tslot_q;
    res_clr_d    = res_clr_q;
    post_hit     = 1'b0;
    take_hit     = 1'b0;
    cmpl_hit     = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          cmd_d        = cmd_e'(in_cmd);
          res_ok_d     = 1'b0;
          res_ticket_d = '0;
          res_tslot_d  = '0;
          res_clr_d    = 1'b0;
          cnt_d        = '0;
          tv_d         = (in_raw != 16'd0) && (in_raw <= 16'(SLOTS));
          ptr_d        = scan_start_q;
          case (cmd_e'(in_cmd))
            CMD_POST: begin
              if (in_handle != '0 && pending_q < CNT_W'(SLOTS)) begin
                state_d = ST_SCAN;
              end else begin
                state_d = ST_RESULT;
              end
            end
            CMD_TAKE: begin
              state_d = (ready_q != '0) ? ST_SCAN : ST_RESULT;
            end
            CMD_COMPLETE: begin
              ptr_d   = in_sidx;
              state_d = ST_CHECK;
            end
            CMD_IS_DONE, CMD_IS_VALID: begin
              ptr_d   = SLOT_W'(in_raw - 16'd1);
              state_d = ST_CHECK;
            end
            default: begin
              state_d = ST_RESULT;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (cmd_q == CMD_POST && cur_done) begin
          post_hit     = 1'b1;
          res_ok_d     = 1'b1;
          res_ticket_d = {salt_inc, slot_field};
          state_d      = ST_RESULT;
        end else if (cmd_q != CMD_POST && !cur_done && !cur_taken) begin
          take_hit    = 1'b1;
          res_ok_d    = 1'b1;
          res_tslot_d = ptr_q;
          state_d     = ST_RESULT;
        end else if (last_step) begin
          state_d = ST_RESULT;
        end else begin
          ptr_d = ptr_inc;
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_CHECK: begin
        case (cmd_q)
          CMD_COMPLETE: begin
            if (!cur_done) begin
              cmpl_hit = 1'b1;
              res_ok_d = 1'b1;
            end
          end
          CMD_IS_DONE: begin
            // null/out-of-range clears; stale salt or finished job answers done
            if (!tv_q) begin
              res_clr_d = 1'b1;
            end else if (!salt_match || cur_done) begin
              res_ok_d  = 1'b1;
              res_clr_d = 1'b1;
            end
          end
          CMD_IS_VALID: begin
            if (tv_q && salt_match && !cur_done) begin
              res_ok_d = 1'b1;
            end else begin
              res_clr_d = 1'b1;
            end
          end
          default: begin
          end
        endcase
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q   <= CMD_POST;
      ptr_q   <= '0;
      cnt_q   <= '0;
      tv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
      tv_q    <= tv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_ok_q     <= res_ok_d;
    res_ticket_q <= res_ticket_d;
    res_tslot_q  <= res_tslot_d;
    res_clr_q    <= res_clr_d;
    if (s_accept) begin
      handle_q <= in_handle;
      arg_q    <= in_arg;
      ticket_q <= in_ticket;
    end
  end

  // Slot flags, salts and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_salt_q[i] <= '0;
      end
      slot_done_q  <= '1;
      slot_taken_q <= '0;
      scan_start_q <= '0;
      pending_q    <= '0;
      ready_q      <= '0;
    end else begin
      if (post_hit) begin
        slot_done_q[ptr_q]  <= 1'b0;
        slot_taken_q[ptr_q] <= 1'b0;
        slot_salt_q[ptr_q]  <= salt_inc;
        if (pending_q == '0) begin
          scan_start_q <= ptr_q;
        end
        pending_q <= pending_q + 1'b1;
        ready_q   <= ready_q + 1'b1;
      end
      if (take_hit) begin
        slot_taken_q[ptr_q] <= 1'b1;
        scan_start_q        <= ptr_inc;
        ready_q             <= ready_q - 1'b1;
      end
      if (cmpl_hit) begin
        // completing an untaken job also retires it from the ready count
        if (!cur_taken && ready_q != '0) begin
          ready_q <= ready_q - 1'b1;
        end
        slot_taken_q[ptr_q] <= 1'b0;
        slot_done_q[ptr_q]  <= 1'b1;
        if (pending_q != '0) begin
          pending_q <= pending_q - 1'b1;
        end
      end
    end
  end

  // Job handle and argument memory
  always_ff @(posedge clk_i) begin
    if (post_hit) begin
      slot_handle_q[ptr_q] <= handle_q;
      slot_arg_q[ptr_q]    <= arg_q;
    end
    if (s_accept) begin
      res_thandle_q <= '0;
      res_targ_q    <= '0;
    end else if (take_hit) begin
      res_thandle_q <= slot_handle_q[ptr_q];
      res_targ_q    <= slot_arg_q[ptr_q];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {5'd0, pending_q, res_clr_q, res_targ_q, res_thandle_q,
                     res_tslot_q, res_ticket_q, res_ok_q};
    end
  end

  // Assertions
  `JST_ASSERT(a_pending_bound, pending_q <= CNT_W'(SLOTS), "pending count above slot count")
  `JST_ASSERT(a_ready_le_pending, ready_q <= pending_q, "ready count above pending count")
  `JST_ASSERT(a_pending_matches_done,
              32'(pending_q) == 32'(SLOTS - $countones(slot_done_q)),
              "pending count disagrees with busy slots")
  `JST_ASSERT_NEXT(a_accept_leaves_idle, s_accept, state_q != ST_IDLE,
                   "sequencer stayed idle after a request")

endmodule

/* dv/tb_job_slot_table_with_tickets_top.sv */
// Self-checking testbench for job_slot_table_with_tickets_top: table-driven directed requests,
// then phased random post/take/complete/query traffic checked against a slot table predictor.
// Depends on jst_pkg and the RTL of job_slot_table_with_tickets_top.
`timescale 1ns / 1ps

module tb_job_slot_table_with_tickets_top;
  import jst_pkg::*;

  // Codes outside the command set; the block must ignore them
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  // Traffic mix of one random phase
  localparam int MODE_MIXED = 0;
  localparam int MODE_FILL  = 1;
  localparam int MODE_DRAIN = 2;

  localparam int NUM_VECS        = 25;
  localparam int RANDOM_ITEMS    = 1500;
  localparam int PHASE_LEN       = 100;
  localparam int QUIET_FROM      = 1300;
  localparam int HOLD_OFF_AT     = 250;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_IDLE        = 18;
  localparam int DRAIN_CYCLES    = 40;
  localparam int MAX_PRINTS      = 100;
  localparam int MAX_TICKETS     = 48;

  // Request fields, listed from the highest bit down
  typedef struct packed {
    logic [31:0] ticket;
    logic [3:0]  slot;
    logic [31:0] argument;
    logic [31:0] handle;
    logic [2:0]  cmd;
  } job_req_t;

  // Result fields, listed from the highest bit down
  typedef struct packed {
    logic [4:0]  incomplete_count;
    logic        clear_ticket;
    logic [31:0] taken_argument;
    logic [31:0] taken_handle;
    logic [3:0]  taken_slot;
    logic [31:0] ticket_out;
    logic        ok;
  } job_result_t;

  // One directed request; the expected result counts only when typed is set
  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] handle;
    logic [31:0] argument;
    logic [3:0]  slot;
    logic [31:0] ticket;
    bit          typed;
    logic        ok;
    logic [31:0] ticket_out;
    logic [3:0]  taken_slot;
    logic [31:0] taken_handle;
    logic [31:0] taken_argument;
    logic        clear_ticket;
    logic [4:0]  incomplete_count;
  } vec_row_t;

  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  // Predicted slot table
  logic [15:0] slot_salt     [SLOTS];
  bit          slot_free     [SLOTS];
  bit          slot_taken    [SLOTS];
  logic [31:0] slot_handle   [SLOTS];
  logic [31:0] slot_argument [SLOTS];
  int          scan_pos;
  int          pending_jobs;
  int          ready_jobs;

  job_result_t expected_results [$];
  logic [31:0] issued_tickets [$];
  int          mismatches   = 0;
  int          results_seen = 0;
  bit          tx_idle_en   = 1'b0;
  bit          rx_idle_en   = 1'b0;
  bit          hold_off_req = 1'b0;

  vec_row_t directed_vecs [NUM_VECS] = '{
    // empty table: take, null tickets, zero handle
    '{CMD_TAKE,     32'h0,        32'h0,        4'h0, 32'h0,
      1'b1, 1'b0, 32'h0,        4'h0, 32'h0,        32'h0,        1'b0, 5'd0},
    '{CMD_IS_DONE,  32'h0,        32'h0,        4'h0, 32'h0,
      1'b1, 1'b0, 32'h0,        4'h0, 32'h0,        32'h0,        1'b1, 5'd0},
    '{CMD_IS_VALID, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'hF, 32'h0,
      1'b1, 1'b0, 32'h0,        4'h0, 32'h0,        32'h0,        1'b1, 5'd0},
    '{CMD_POST,     32'h0,        32'hFFFFFFFF, 4'hF, 32'hFFFFFFFF,
      1'b1, 1'b0, 32'h0,        4'h0, 32'h0,        32'h0,        1'b0, 5'd0},
    // first post lands in slot 0 with salt 1
    '{CMD_POST,     32'hFFFFFFFF, 32'hFFFFFFFF, 4'h0, 32'h0,
      1'b1, 1'b1, 32'h00010001, 4'h0, 32'h0,        32'h0,        1'b0, 5'd1},
    '{CMD_IS_VALID, 32'h0,        32'h0,        4'h0, 32'h00010001,
      1'b1, 1'b1, 32'h0,        4'h0, 32'h0,        32'h0,        1'b0, 5'd1},
    '{CMD_IS_DONE,  32'h0,        32'h0,        4'h0, 32'h00010001,
      1'b1, 1'b0, 32'h0,        4'h0, 32'h0,        32'h0,        1'b0, 5'd1},
    // stale salt, then slot parts past the table
    '{CMD_IS_DONE,  32'h0,        32'h0,        4'h0, 32'h00020001,
      1'b1, 1'b1, 32'h0,        4'h0, 32'h0,        32'h0,        1'b1, 5'd1},
    '{CMD_IS_VALID, 32'h0,        32'h0,        4'h0, 32'hFFFF0011,
      1'b1, 1'b0, 32'h0,        4'h0, 32'h0,        32'h0,        1'b1, 5'd1},
    '{CMD_IS_DONE,  32'h0,        32'h0,        4'h0, 32'h0000FFFF,
      1'b1, 1'b0, 32'h0,        4'h0, 32'h0,        32'h0,        1'b1, 5'd1},
    // completing a free slot is refused
    '{CMD_COMPLETE, 32'h0,        32'h0,        4'hF, 32'h0,
      1'b1, 1'b0, 32'h0,        4'h0, 32'h0,        32'h0,        1'b0, 5'd1},
    '{CMD_TAKE,     32'h0,        32'h0,        4'h0, 32'h0,
      1'b1, 1'b1, 32'h0,        4'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 5'd1},
    '{CMD_COMPLETE, 32'h0,        32'h0,        4'h0, 32'h0,
      1'b1, 1'b1, 32'h0,        4'h0, 32'h0,        32'h0,        1'b0, 5'd0},
    '{CMD_IS_DONE,  32'h0,        32'h0,        4'h0, 32'h00010001,
      1'b1, 1'b1, 32'h0,        4'h0, 32'h0,        32'h0,        1'b1, 5'd0},
    '{CMD_IS_VALID, 32'h0,        32'h0,        4'h0, 32'h00010001,
      1'b1, 1'b0, 32'h0,        4'h0, 32'h0,        32'h0,        1'b1, 5'd0},
    // unused codes with every other bit set
    '{CMD_RSVD5,    32'hFFFFFFFF, 32'hFFFFFFFF, 4'hF, 32'hFFFFFFFF,
      1'b1, 1'b0, 32'h0,        4'h0, 32'h0,        32'h0,        1'b0, 5'd0},
    '{CMD_RSVD6,    32'hFFFFFFFF, 32'hFFFFFFFF, 4'hF, 32'hFFFFFFFF,
      1'b1, 1'b0, 32'h0,        4'h0, 32'h0,        32'h0,        1'b0, 5'd0},
    '{CMD_RSVD7,    32'hFFFFFFFF, 32'hFFFFFFFF, 4'hF, 32'hFFFFFFFF,
      1'b1, 1'b0, 32'h0,        4'h0, 32'h0,        32'h0,        1'b0, 5'd0},
    // idle table: scan restarts past the last take, at slot 1
    '{CMD_POST,     32'h00000001, 32'h0,        4'h0, 32'h0,
      1'b1, 1'b1, 32'h00010002, 4'h0, 32'h0,        32'h0,        1'b0, 5'd1},
    // complete before take drops the ready count too
    '{CMD_COMPLETE, 32'h0,        32'h0,        4'h1, 32'h0,
      1'b1, 1'b1, 32'h0,        4'h0, 32'h0,        32'h0,        1'b0, 5'd0},
    '{CMD_TAKE,     32'h0,        32'h0,        4'h0, 32'h0,
      1'b1, 1'b0, 32'h0,        4'h0, 32'h0,        32'h0,        1'b0, 5'd0},
    '{CMD_POST,     32'h80000000, 32'h12345678, 4'h0, 32'h0,
      1'b0, 1'b0, 32'h0,        4'h0, 32'h0,        32'h0,        1'b0, 5'd0},
    '{CMD_POST,     32'h00000001, 32'hFFFFFFFF, 4'h0, 32'h0,
      1'b0, 1'b0, 32'h0,        4'h0, 32'h0,        32'h0,        1'b0, 5'd0},
    '{CMD_TAKE,     32'h0,        32'h0,        4'h0, 32'h0,
      1'b0, 1'b0, 32'h0,        4'h0, 32'h0,        32'h0,        1'b0, 5'd0},
    '{CMD_IS_VALID, 32'h0,        32'h0,        4'h0, 32'h00020002,
      1'b0, 1'b0, 32'h0,        4'h0, 32'h0,        32'h0,        1'b0, 5'd0}
  };

  job_slot_table_with_tickets_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Applies one request to the predicted table and returns its result
  function automatic job_result_t table_step(job_req_t r);
    job_result_t res;
    int  i;
    int  j;
    int  raw;
    bit  found;
    bit  hit;
    bit  match;
    bit  fin;
    res   = '0;
    found = 1'b0;
    case (r.cmd)
      CMD_POST: begin
        if (r.handle != '0 && pending_jobs < SLOTS) begin
          for (i = 0; i < SLOTS; i++) begin
            j = (scan_pos + i) % SLOTS;
            if (!found && slot_free[j]) begin
              found = 1'b1;
              if (pending_jobs == 0) scan_pos = j;
              slot_taken[j]    = 1'b0;
              slot_free[j]     = 1'b0;
              slot_salt[j]     = slot_salt[j] + 16'd1;
              slot_handle[j]   = r.handle;
              slot_argument[j] = r.argument;
              ready_jobs++;
              pending_jobs++;
              res.ok         = 1'b1;
              res.ticket_out = {slot_salt[j], 16'(j + 1)};
            end
          end
        end
      end
      CMD_TAKE: begin
        if (ready_jobs != 0) begin
          for (i = 0; i < SLOTS; i++) begin
            j = (scan_pos + i) % SLOTS;
            if (!found && !slot_free[j] && !slot_taken[j]) begin
              found = 1'b1;
              scan_pos = (j + 1) % SLOTS;
              ready_jobs--;
              slot_taken[j]      = 1'b1;
              res.ok             = 1'b1;
              res.taken_slot     = 4'(j);
              res.taken_handle   = slot_handle[j];
              res.taken_argument = slot_argument[j];
            end
          end
        end
      end
      CMD_COMPLETE: begin
        j = int'(r.slot);
        if (j < SLOTS && !slot_free[j]) begin
          if (!slot_taken[j] && ready_jobs != 0) ready_jobs--;
          slot_taken[j] = 1'b0;
          slot_free[j]  = 1'b1;
          if (pending_jobs != 0) pending_jobs--;
          res.ok = 1'b1;
        end
      end
      CMD_IS_DONE, CMD_IS_VALID: begin
        raw   = int'(r.ticket[15:0]);
        hit   = (raw != 0) && (raw <= SLOTS);
        match = 1'b0;
        fin   = 1'b0;
        if (hit) begin
          match = (slot_salt[raw - 1] == r.ticket[31:16]);
          fin   = slot_free[raw - 1];
        end
        if (r.cmd == CMD_IS_DONE) begin
          // stale ticket or finished job both mean done
          if (!hit) begin
            res.clear_ticket = 1'b1;
          end else if (!match || fin) begin
            res.ok           = 1'b1;
            res.clear_ticket = 1'b1;
          end
        end else if (hit && match && !fin) begin
          res.ok = 1'b1;
        end else begin
          res.clear_ticket = 1'b1;
        end
      end
      default: ;
    endcase
    res.incomplete_count = 5'(pending_jobs);
    return res;
  endfunction

  // Random request; most follow the live table so posts, takes and tickets land
  function automatic job_req_t random_request(int mode);
    job_req_t r;
    int pick;
    int j;
    int post_pct;
    int take_pct;
    int done_pct;
    int busy [$];
    r.cmd      = 3'($urandom_range(0, 7));
    r.handle   = $urandom;
    r.argument = $urandom;
    r.slot     = 4'($urandom_range(0, 15));
    r.ticket   = $urandom;
    // a share of pure noise
    if ($urandom_range(0, 99) < 8) return r;
    case (mode)
      MODE_FILL:  begin post_pct = 60; take_pct = 15; done_pct = 10; end
      MODE_DRAIN: begin post_pct = 10; take_pct = 35; done_pct = 35; end
      default:    begin post_pct = 30; take_pct = 25; done_pct = 25; end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < post_pct) begin
      r.cmd = CMD_POST;
      if ($urandom_range(0, 99) < 4) r.handle = '0;
    end else if (pick < post_pct + take_pct) begin
      r.cmd = CMD_TAKE;
    end else if (pick < post_pct + take_pct + done_pct) begin
      r.cmd = CMD_COMPLETE;
      for (j = 0; j < SLOTS; j++) if (!slot_free[j]) busy.push_back(j);
      if (busy.size() != 0 && $urandom_range(0, 99) < 80)
        r.slot = 4'(busy[$urandom_range(0, busy.size() - 1)]);
    end else begin
      r.cmd = ($urandom_range(0, 1) == 1) ? CMD_IS_DONE : CMD_IS_VALID;
      pick  = $urandom_range(0, 99);
      if (pick < 55 && issued_tickets.size() != 0) begin
        r.ticket = issued_tickets[$urandom_range(0, issued_tickets.size() - 1)];
      end else if (pick < 80) begin
        // current salt or one off
        j = $urandom_range(0, SLOTS - 1);
        r.ticket = {slot_salt[j] + 16'($urandom_range(0, 2)) - 16'd1, 16'(j + 1)};
      end else if (pick < 90) begin
        r.ticket[15:0] = 16'($urandom_range(0, SLOTS + 1));
      end
    end
    return r;
  endfunction

  // Offers one request, waits for the handshake, and queues its result
  task automatic send_request(job_req_t r, bit typed, job_result_t typed_res);
    job_result_t predicted;
    int gap;
    if (tx_idle_en && $urandom_range(0, 99) < 20) begin
      gap = $urandom_range(1, MAX_IDLE);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W - $bits(job_req_t)){1'b0}}, r};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = table_step(r);
    if (r.cmd == CMD_POST && predicted.ok) begin
      issued_tickets.push_back(predicted.ticket_out);
      if (issued_tickets.size() > MAX_TICKETS) void'(issued_tickets.pop_front());
    end
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("result %0d: %s got %h expected %h", results_seen, field, got, exp);
  endtask

  task automatic compare_result(job_result_t got, job_result_t exp);
    if (got.ok !== exp.ok) report_mismatch("ok", 32'(got.ok), 32'(exp.ok));
    if (got.ticket_out !== exp.ticket_out)
      report_mismatch("ticket_out", got.ticket_out, exp.ticket_out);
    if (got.taken_slot !== exp.taken_slot)
      report_mismatch("taken_slot", 32'(got.taken_slot), 32'(exp.taken_slot));
    if (got.taken_handle !== exp.taken_handle)
      report_mismatch("taken_handle", got.taken_handle, exp.taken_handle);
    if (got.taken_argument !== exp.taken_argument)
      report_mismatch("taken_argument", got.taken_argument, exp.taken_argument);
    if (got.clear_ticket !== exp.clear_ticket)
      report_mismatch("clear_ticket", 32'(got.clear_ticket), 32'(exp.clear_ticket));
    if (got.incomplete_count !== exp.incomplete_count)
      report_mismatch("incomplete_count", 32'(got.incomplete_count),
                      32'(exp.incomplete_count));
  endtask

  // Result check at each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[31:0], 32'h0);
      end else begin
        compare_result(job_result_t'(m_axis_tdata[$bits(job_result_t)-1:0]),
                       expected_results.pop_front());
      end
      results_seen++;
    end
  end

  // Result side: random stall bursts plus one long hold-off
  initial begin
    int stall_left;
    bit held;
    stall_left = 0;
    held       = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_off_req && !held) begin
        held       = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
      end else if (rx_idle_en && $urandom_range(0, 99) < 15) begin
        stall_left = $urandom_range(1, MAX_IDLE);
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  // Reset, directed table, random phases, drain
  initial begin
    job_req_t    r;
    job_result_t res;
    int          mode;
    int          n;
    for (n = 0; n < SLOTS; n++) begin
      slot_salt[n]     = '0;
      slot_free[n]     = 1'b1;
      slot_taken[n]    = 1'b0;
      slot_handle[n]   = '0;
      slot_argument[n] = '0;
    end
    scan_pos     = 0;
    pending_jobs = 0;
    ready_jobs   = 0;
    mode         = MODE_MIXED;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows, no idling on the request side
    for (n = 0; n < NUM_VECS; n++) begin
      r.cmd                = directed_vecs[n].cmd;
      r.handle             = directed_vecs[n].handle;
      r.argument           = directed_vecs[n].argument;
      r.slot               = directed_vecs[n].slot;
      r.ticket             = directed_vecs[n].ticket;
      res.ok               = directed_vecs[n].ok;
      res.ticket_out       = directed_vecs[n].ticket_out;
      res.taken_slot       = directed_vecs[n].taken_slot;
      res.taken_handle     = directed_vecs[n].taken_handle;
      res.taken_argument   = directed_vecs[n].taken_argument;
      res.clear_ticket     = directed_vecs[n].clear_ticket;
      res.incomplete_count = directed_vecs[n].incomplete_count;
      send_request(r, directed_vecs[n].typed, res);
    end

    // random phases; fill then drain early so the table runs full
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        case (n / PHASE_LEN)
          1:       mode = MODE_FILL;
          2:       mode = MODE_DRAIN;
          default: mode = $urandom_range(MODE_MIXED, MODE_DRAIN);
        endcase
        tx_idle_en = (n < QUIET_FROM) && ($urandom_range(0, 3) != 0);
        rx_idle_en = (n < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      end
      if (n == HOLD_OFF_AT) hold_off_req = 1'b1;
      send_request(random_request(mode), 1'b0, '0);
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** job_slot_table_with_tickets_top: PASSED **");
    end else begin
      $display("** job_slot_table_with_tickets_top: FAILED **");
    end
    $finish;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("** job_slot_table_with_tickets_top: FAILED **");
    $finish;
  end

endmodule
